FILE: rtl/core/pge_pkg.sv
// Shared constants, register indexes and controller/datapath interface types.
`timescale 1ns / 1ps
package pge_pkg;

  localparam int MAX_ORDER  = 5;
  localparam int MAX_POINTS = 65536;
  localparam int NUM_COEF   = MAX_ORDER + 1;
  localparam int N_W        = $clog2(MAX_POINTS + 1);
  localparam int K_W        = 3;
  localparam int X_W        = 34;

  localparam logic [2:0]  REG_ORDER  = 3'd0;
  localparam logic [2:0]  REG_COEF0  = 3'd1;
  localparam logic [2:0]  REG_COEF5  = 3'd6;
  localparam logic [2:0]  REG_STEP   = 3'd7;
  localparam logic [30:0] STEP_RESET = 31'd105;

  typedef struct packed {
    logic load;
    logic eval_init;
    logic mul_start;
    logic mul_pow;
    logic pow_wr;
    logic acc_wr;
    logic update;
    logic out_load;
  } pge_cmd_t;

  typedef struct packed {
    logic in_range;
    logic n_full;
    logic k_last;
    logic mul_done;
  } pge_sts_t;

endpackage

FILE: rtl/core/pge_mul.sv
// Multi-cycle saturating fixed-point multiplier: floor(a * b / 2^s), s of 16 or 20.
`timescale 1ns / 1ps
module pge_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [31:0] b,
  input  logic               sh20,
  output logic signed [63:0] res,
  output logic               done
);
  import pge_pkg::*;

  logic [63:0] am_r;
  logic [31:0] bm_r;
  logic        neg_r;
  logic        sh20_r;
  logic [63:0] pp_lo_r;
  logic [63:0] pp_hi_r;
  logic [63:0] res_r;
  logic [2:0]  ph_r;
  logic [2:0]  ph_nxt;
  logic        done_r;

  logic [31:0] mul_op;
  logic [63:0] mul_pp;
  logic [95:0] full;
  logic [95:0] rounded;
  logic [79:0] q;
  logic        ovf;
  logic [63:0] sat;

  assign ph_nxt = {ph_r[1:0], start};
  assign mul_op = ph_r[1] ? am_r[63:32] : am_r[31:0];
  assign mul_pp = mul_op * bm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= 3'b000;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= ph_r[2];
    end
  end

  always_comb begin
    full    = {pp_hi_r, 32'd0} + {32'd0, pp_lo_r};
    rounded = full;
    if (neg_r) begin
      rounded = full + (sh20_r ? 96'h0F_FFFF : 96'h0_FFFF);
    end
    q   = sh20_r ? {4'd0, rounded[95:20]} : rounded[95:16];
    ovf = (|q[79:64]) | q[63];
    if (neg_r) begin
      sat = ovf ? 64'h8000_0000_0000_0000 : (64'd0 - q[63:0]);
    end else begin
      sat = ovf ? 64'h7FFF_FFFF_FFFF_FFFF : q[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      am_r   <= a[63] ? (64'd0 - a) : a;
      bm_r   <= b[31] ? (32'd0 - b) : b;
      neg_r  <= a[63] ^ b[31];
      sh20_r <= sh20;
    end
    if (ph_r[0]) begin
      pp_lo_r <= mul_pp;
    end
    if (ph_r[1]) begin
      pp_hi_r <= mul_pp;
    end
    if (ph_r[2]) begin
      res_r <= sat;
    end
  end

  assign res  = res_r;
  assign done = done_r;

endmodule

FILE: rtl/core/pge_datapath.sv
// Datapath: configuration registers, sweep state, polynomial accumulator, result registers.
`timescale 1ns / 1ps
module pge_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [31:0]        cfg_wdata,
  input  logic               req_func,
  input  logic signed [31:0] req_start,
  input  logic signed [31:0] req_end,
  input  pge_pkg::pge_cmd_t  cmd,
  output pge_pkg::pge_sts_t  sts,
  output logic signed [63:0] res_value,
  output logic signed [31:0] res_x,
  output logic               res_empty,
  output logic               res_trunc
);
  import pge_pkg::*;

  logic [2:0]         order_r;
  logic signed [31:0] coef_r [NUM_COEF];
  logic [30:0]        step_r;

  logic signed [X_W-1:0] x_r;
  logic signed [31:0]    end_r;
  logic                  min_r;
  logic [N_W-1:0]        n_r;
  logic signed [63:0]    p_r;
  logic signed [63:0]    acc_r;
  logic signed [63:0]    best_r;
  logic signed [31:0]    bestx_r;
  logic                  have_r;
  logic [K_W-1:0]        k_r;

  logic signed [63:0] val_r;
  logic signed [31:0] xo_r;
  logic               empty_r;
  logic               trunc_r;

  logic [K_W-1:0]     order_eff;
  logic signed [31:0] mul_b;
  logic signed [63:0] mul_res;
  logic               mul_done;
  logic signed [63:0] acc_nxt;
  logic [64:0]        acc_sum;
  logic               better;

  assign order_eff = (order_r > K_W'(MAX_ORDER)) ? K_W'(MAX_ORDER) : order_r;
  assign mul_b     = cmd.mul_pow ? x_r[31:0] : coef_r[k_r];

  pge_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (p_r),
    .b     (mul_b),
    .sh20  (cmd.mul_pow),
    .res   (mul_res),
    .done  (mul_done)
  );

  always_comb begin
    acc_sum = {acc_r[63], acc_r} + {mul_res[63], mul_res};
    acc_nxt = acc_sum[63:0];
    if (acc_r[63] == mul_res[63] && acc_sum[63] != acc_r[63]) begin
      acc_nxt = acc_r[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    end
    better = !have_r || (min_r ? (acc_r < best_r) : (acc_r > best_r));
  end

  assign sts.in_range = (x_r <= X_W'(end_r));
  assign sts.n_full   = (n_r == N_W'(MAX_POINTS));
  assign sts.k_last   = (k_r == order_eff);
  assign sts.mul_done = mul_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= 3'd0;
      step_r  <= STEP_RESET;
      for (int i = 0; i < NUM_COEF; i++) begin
        coef_r[i] <= 32'sd0;
      end
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ORDER: order_r <= cfg_wdata[2:0];
        REG_STEP:  step_r  <= cfg_wdata[30:0];
        default: begin
          if (cfg_idx inside {[REG_COEF0:REG_COEF5]}) begin
            coef_r[K_W'(cfg_idx - REG_COEF0)] <= cfg_wdata;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r     <= X_W'(req_start);
      end_r   <= req_end;
      min_r   <= req_func;
      n_r     <= '0;
      have_r  <= 1'b0;
      best_r  <= 64'sd0;
      bestx_r <= 32'sd0;
    end
    if (cmd.eval_init) begin
      p_r   <= 64'sh1_0000_0000;
      acc_r <= 64'sd0;
      k_r   <= '0;
    end
    if (cmd.pow_wr) begin
      p_r <= mul_res;
      k_r <= k_r + K_W'(1);
    end
    if (cmd.acc_wr) begin
      acc_r <= acc_nxt;
    end
    if (cmd.update) begin
      if (better) begin
        best_r  <= acc_r;
        bestx_r <= x_r[31:0];
        have_r  <= 1'b1;
      end
      n_r <= n_r + N_W'(1);
      x_r <= x_r + X_W'(step_r);
    end
    if (cmd.out_load) begin
      val_r   <= best_r;
      xo_r    <= bestx_r;
      empty_r <= (n_r == '0) && !sts.in_range;
      trunc_r <= sts.n_full && sts.in_range;
    end
  end

  assign res_value = val_r;
  assign res_x     = xo_r;
  assign res_empty = empty_r;
  assign res_trunc = trunc_r;

endmodule

FILE: rtl/core/pge_ctrl.sv
// Controller: sequences grid points, polynomial terms and result hand-off.
`timescale 1ns / 1ps
module pge_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  pge_pkg::pge_sts_t sts,
  output pge_pkg::pge_cmd_t cmd
);
  import pge_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE      = 8'b0000_0001,
    ST_CHECK     = 8'b0000_0010,
    ST_TERM      = 8'b0000_0100,
    ST_TERM_WAIT = 8'b0000_1000,
    ST_POW       = 8'b0001_0000,
    ST_POW_WAIT  = 8'b0010_0000,
    ST_UPDATE    = 8'b0100_0000,
    ST_DONE      = 8'b1000_0000
  } pge_state_t;

  pge_state_t state_r;
  pge_state_t state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r & ~out_tready;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!sts.in_range || sts.n_full) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.eval_init = 1'b1;
          state_nxt     = ST_TERM;
        end
      end
      ST_TERM: begin
        cmd.mul_start = 1'b1;
        state_nxt     = ST_TERM_WAIT;
      end
      ST_TERM_WAIT: begin
        if (sts.mul_done) begin
          cmd.acc_wr = 1'b1;
          state_nxt  = sts.k_last ? ST_UPDATE : ST_POW;
        end
      end
      ST_POW: begin
        cmd.mul_start = 1'b1;
        cmd.mul_pow   = 1'b1;
        state_nxt     = ST_POW_WAIT;
      end
      ST_POW_WAIT: begin
        if (sts.mul_done) begin
          cmd.pow_wr = 1'b1;
          state_nxt  = ST_TERM;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_CHECK;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

FILE: rtl/core/polynomial_grid_extremum_core.sv
// Grid-search extremum of a configured fixed-point polynomial over a requested x range.
//
// Channels: in_* carries one sweep request (range start and end in tdata, max/min
// selector in tuser); out_* returns one result per request (extreme value and its x
// in tdata, empty-range and truncated flags in tuser). cfg_* writes the polynomial
// order, the six coefficients and the grid step; it is always ready and must only be
// written while no request is in flight.
// One shared 32x32 multiplier, used twice per 64x32 product, computes every product. Each
// grid point accumulates terms 0 to order in turn (order capped at 5). An empty range
// returns without evaluating any point; at most 65536 points are evaluated per request.
// One request is worked at a time; in_tready is high while the core is idle.
// The result sits in an output register, so a new request is accepted while it waits;
// a stalled receiver holds the finished sweep only when a second result is ready.
// Reset (synchronous, active low) clears the sequencer and output valid and restores
// the register defaults: order 0, coefficients 0, step 105.
`timescale 1ns / 1ps
module polynomial_grid_extremum_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] range_start, [63:32] range_end
  input  logic [0:0]  in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // [63:0] extreme_value, [95:64] extreme_x
  output logic [1:0]  out_tuser,  // [0] empty_range, [1] truncated
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import pge_pkg::*;

  pge_cmd_t           cmd;
  pge_sts_t           sts;
  logic signed [63:0] res_value;
  logic signed [31:0] res_x;
  logic               res_empty;
  logic               res_trunc;

  assign cfg_ready = 1'b1;

  pge_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  pge_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .req_func  (in_tuser[0]),
    .req_start (in_tdata[31:0]),
    .req_end   (in_tdata[63:32]),
    .cmd       (cmd),
    .sts       (sts),
    .res_value (res_value),
    .res_x     (res_x),
    .res_empty (res_empty),
    .res_trunc (res_trunc)
  );

  assign out_tdata = {res_x, res_value};
  assign out_tuser = {res_trunc, res_empty};

endmodule

FILE: tb/tb_polynomial_grid_extremum_core.sv
// Self-checking testbench for the polynomial grid-search extremum core.
`timescale 1ns / 1ps
module tb_polynomial_grid_extremum_core;
  import pge_pkg::*;

  localparam logic FUNC_MAX = 1'b0;
  localparam logic FUNC_MIN = 1'b1;
  localparam logic signed [31:0] X_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] X_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] ONE_Q20 = 32'sh0010_0000;
  localparam logic signed [127:0] SAT_HI = 128'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [127:0] SAT_LO = -SAT_HI - 128'sd1;
  localparam int unsigned WATCHDOG_LIMIT = 2_000_000;

  typedef struct packed {
    logic [63:0] value;
    logic [31:0] x;
    logic        empty;
    logic        trunc;
  } sweep_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;   // [31:0] range_start, [63:32] range_end
  logic [0:0]  in_tuser   = '0;   // [0] func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;         // [63:0] extreme_value, [95:64] extreme_x
  logic [1:0]  out_tuser;         // [0] empty_range, [1] truncated
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index  = '0;
  logic [31:0] cfg_data   = '0;

  // register copies seen by the predictor
  logic [2:0]         cur_order = 3'd0;
  logic signed [31:0] cur_coef [NUM_COEF];
  logic [30:0]        cur_step  = STEP_RESET;

  sweep_result_t result_q [$];
  sweep_result_t due;
  int          err_count    = 0;
  int          idle_pct     = 0;
  int          stall_pct    = 0;
  int unsigned quiet_cycles = 0;

  polynomial_grid_extremum_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  initial begin
    for (int k = 0; k < NUM_COEF; k++) cur_coef[k] = '0;
  end

  function automatic logic signed [63:0] fx_mul_floor(input logic signed [63:0] a,
                                                       input logic signed [31:0] b,
                                                       input int unsigned sh);
    logic signed [127:0] wa, wb, prod;
    wa = a;
    wb = b;
    prod = (wa * wb) >>> sh;
    if (prod > SAT_HI) return SAT_HI[63:0];
    if (prod < SAT_LO) return SAT_LO[63:0];
    return prod[63:0];
  endfunction

  function automatic logic signed [63:0] fx_add_sat(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
    logic signed [64:0] wa, wb, s;
    wa = a;
    wb = b;
    s = wa + wb;
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] poly_value(input logic signed [31:0] x);
    logic signed [63:0] pw, acc;
    int top;
    top = (cur_order > MAX_ORDER) ? MAX_ORDER : cur_order;
    pw = 64'sh1_0000_0000;
    acc = '0;
    for (int k = 0; k <= top; k++) begin
      if (k > 0) pw = fx_mul_floor(pw, x, 20);
      acc = fx_add_sat(acc, fx_mul_floor(pw, cur_coef[k], 16));
    end
    return acc;
  endfunction

  function automatic sweep_result_t predict_sweep(input logic func,
                                                  input logic signed [31:0] first_x,
                                                  input logic signed [31:0] last_x);
    sweep_result_t r;
    longint x, lim;
    int unsigned n;
    logic signed [63:0] y, best;
    bit have;
    r = '0;
    if (first_x > last_x) begin
      r.empty = 1'b1;
      return r;
    end
    x = first_x;
    lim = last_x;
    n = 0;
    have = 1'b0;
    best = '0;
    while (x <= lim && !r.trunc) begin
      if (n >= MAX_POINTS) begin
        r.trunc = 1'b1;
      end else begin
        y = poly_value(x[31:0]);
        if (!have || ((func == FUNC_MIN) ? (y < best) : (y > best))) begin
          best = y;
          r.x = x[31:0];
          have = 1'b1;
        end
        n++;
        x = x + longint'(cur_step);
      end
    end
    r.value = best;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    err_count++;
  endtask

  always @(negedge clk) out_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (result_q.size() == 0) begin
        report_mismatch("unexpected result", out_tdata[63:0], '0);
      end else begin
        due = result_q.pop_front();
        if (out_tdata[63:0] !== due.value)
          report_mismatch("extreme_value", out_tdata[63:0], due.value);
        if (out_tdata[95:64] !== due.x)
          report_mismatch("extreme_x", 64'(out_tdata[95:64]), 64'(due.x));
        if (out_tuser[0] !== due.empty)
          report_mismatch("empty_range", 64'(out_tuser[0]), 64'(due.empty));
        if (out_tuser[1] !== due.trunc)
          report_mismatch("truncated", 64'(out_tuser[1]), 64'(due.trunc));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL polynomial_grid_extremum_core");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] index, input logic [31:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      REG_ORDER: cur_order = data[2:0];
      REG_STEP:  cur_step  = data[30:0];
      default:   cur_coef[index - REG_COEF0] = data;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_poly(input logic [2:0] order, input logic [5:0][31:0] coefs,
                          input logic [30:0] step);
    logic [31:0] r;
    r = $urandom;
    write_reg(REG_ORDER, {r[31:3], order});
    for (int k = 0; k < NUM_COEF; k++) write_reg(REG_COEF0 + 3'(k), coefs[k]);
    r = $urandom;
    write_reg(REG_STEP, {r[31], step});
  endtask

  task automatic send_sweep(input logic func, input logic signed [31:0] first_x,
                            input logic signed [31:0] last_x);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    result_q.push_back(predict_sweep(func, first_x, last_x));
    in_tvalid = 1'b1;
    in_tdata  = {last_x, first_x};
    in_tuser  = func;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h2_0000) - 32'h1_0000;
      2: return ($urandom_range(1)) ? X_MAX : X_MIN;
      default: return $urandom_range(0, 32'h80_0000) - 32'h40_0000;
    endcase
  endfunction

  function automatic logic [30:0] rand_step();
    case ($urandom_range(3))
      0: return 31'($urandom_range(1, 200));
      1: return 31'($urandom_range(1, 32'h10_0000));
      2: return 31'($urandom_range(1, 32'h7FFF_FFFF));
      default: return ($urandom_range(1)) ? 31'h7FFF_FFFF : 31'd1;
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_sweep(FUNC_MAX, X_MIN, X_MIN + 300);
    send_sweep(FUNC_MIN, X_MAX, X_MAX);
    send_sweep(FUNC_MAX, 32'sd1, 32'sd0);
    settle();
  endtask

  task automatic test_extremes();
    logic [5:0][31:0] c;
    c = {X_MIN, X_MAX, X_MIN, X_MAX, X_MIN, X_MAX};
    set_poly(3'd5, c, ONE_Q20[30:0]);
    send_sweep(FUNC_MAX, X_MIN, X_MIN + 3 * ONE_Q20);
    send_sweep(FUNC_MIN, X_MIN, X_MIN + 3 * ONE_Q20);
    send_sweep(FUNC_MAX, X_MAX - 2 * ONE_Q20, X_MAX);
    send_sweep(FUNC_MIN, -3 * ONE_Q20, 3 * ONE_Q20);
    send_sweep(FUNC_MAX, X_MAX, X_MIN);
    settle();
    for (int k = 0; k < NUM_COEF; k++) c[k] = $urandom_range(0, 32'h2_0000) - 32'h1_0000;
    set_poly(3'd7, c, 31'h7FFF_FFFF);
    send_sweep(FUNC_MAX, X_MIN, X_MAX);
    send_sweep(FUNC_MIN, X_MIN, X_MAX);
    send_sweep(FUNC_MAX, X_MAX - 5, X_MAX);
    settle();
    set_poly(3'd6, c, 31'h20);
    send_sweep(FUNC_MIN, 32'sh7FFF_FF00, X_MAX);
    settle();
  endtask

  task automatic test_ties();
    logic [5:0][31:0] c;
    c = '0;
    c[2] = 32'sh0001_0000;
    set_poly(3'd2, c, ONE_Q20[30:0]);
    send_sweep(FUNC_MAX, -3 * ONE_Q20, 3 * ONE_Q20);
    send_sweep(FUNC_MIN, -3 * ONE_Q20, 3 * ONE_Q20 + ONE_Q20 - 1);
    settle();
    c[2] = -32'sh0001_0000;
    set_poly(3'd2, c, ONE_Q20[30:0]);
    send_sweep(FUNC_MIN, -3 * ONE_Q20, 3 * ONE_Q20);
    settle();
    set_poly(3'd4, '0, 31'd777);
    send_sweep(FUNC_MIN, -5 * ONE_Q20, -5 * ONE_Q20 + 5000);
    settle();
  endtask

  task automatic test_truncation();
    logic [5:0][31:0] c;
    c = '0;
    c[0] = rand_coef();
    set_poly(3'd0, c, 31'd1);
    send_sweep(FUNC_MAX, -32'sd1000, -32'sd1000 + MAX_POINTS);
    settle();
    // zero step: x never advances
    set_poly(3'd0, c, 31'd0);
    send_sweep(FUNC_MIN, 32'sh1234, 32'sh1234);
    settle();
  endtask

  task automatic random_sweep();
    logic func;
    int first_x;
    longint stop;
    int npts;
    func = $urandom_range(1);
    if ($urandom_range(9) == 0) begin
      first_x = $urandom;
      stop = int'($urandom);
      if (longint'(first_x) < stop) begin
        first_x = int'(stop);
        stop = longint'(first_x) - longint'($urandom_range(1, 1000));
        if (stop < longint'(X_MIN)) stop = X_MIN;
      end
    end else begin
      case ($urandom_range(3))
        0: first_x = $urandom;
        1: first_x = X_MIN + int'($urandom_range(0, 1000));
        2: first_x = X_MAX - int'($urandom_range(0, 1000));
        default: first_x = int'($urandom_range(0, 32'h40_0000)) - 32'sh20_0000;
      endcase
      npts = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      stop = longint'(first_x) + longint'(npts - 1) * longint'(cur_step)
             + longint'($urandom_range(0, cur_step - 1));
      if (stop > longint'(X_MAX)) stop = X_MAX;
    end
    send_sweep(func, first_x, stop[31:0]);
  endtask

  task automatic test_random_sweeps();
    logic [5:0][31:0] c;
    logic [2:0] order;
    int idle_set [4];
    int stall_set [4];
    idle_set  = '{0, 61, 0, 12};
    stall_set = '{0, 0, 61, 12};
    for (int ph = 0; ph < 4; ph++) begin
      for (int sub = 0; sub < 2; sub++) begin
        idle_pct  = 0;
        stall_pct = 0;
        for (int k = 0; k < NUM_COEF; k++) c[k] = rand_coef();
        case (ph)
          0: order = (sub == 0) ? 3'd5 : 3'd0;
          1: order = 3'($urandom_range(1, 4));
          2: order = 3'd7;
          default: order = 3'($urandom_range(0, 7));
        endcase
        set_poly(order, c, rand_step());
        idle_pct  = idle_set[ph];
        stall_pct = stall_set[ph];
        repeat (10) random_sweep();
        settle();
      end
    end
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_defaults();
    test_extremes();
    test_ties();
    test_truncation();
    test_random_sweeps();
    settle();
    repeat (50) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS polynomial_grid_extremum_core");
    end else begin
      $display("FAIL polynomial_grid_extremum_core");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/pge_pkg.sv
rtl/core/pge_mul.sv
rtl/core/pge_datapath.sv
rtl/core/pge_ctrl.sv
rtl/core/polynomial_grid_extremum_core.sv
tb/tb_polynomial_grid_extremum_core.sv
